// File: sv/mmpi_pkg.sv
// ----------------------------------------------------------------------------
// mmpi_pkg
// Shared types and constants for the modular multiply / power / inverse unit.
// ----------------------------------------------------------------------------
package mmpi_pkg;

  // Fixed field widths
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned FIRST_W  = 32;

  // Modulus after reset
  localparam int unsigned MODULUS_RESET = 32'd1000000007;

  // Operation codes
  typedef enum logic [OPCODE_W-1:0] {
    OP_MUL  = 2'd0,
    OP_POW  = 2'd1,
    OP_INV  = 2'd2,
    OP_NONE = 2'd3
  } opcode_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_PCHK,
    S_DBL,
    S_ADD,
    S_MEND,
    S_DONE
  } state_e;

  // Where a finished product goes
  typedef enum logic [1:0] {
    RET_OUT,
    RET_ACC,
    RET_BASE
  } ret_e;

endpackage

// File: sv/modular_mul_pow_inverse.sv
// ----------------------------------------------------------------------------
// modular_mul_pow_inverse
// Modular multiply, power and Fermat inverse over a configured modulus.
// ----------------------------------------------------------------------------
// One word in gives one result word. All modular arithmetic runs on a single
// shared modular adder, one addition per cycle, and the block takes no new word
// until the result has been taken. Unless the modulus is below 2 or the
// opcode is 3, an operation first reduces the first operand bit by bit.
// Multiply (opcode 0) then runs one interleaved double-and-add pass over the
// EXP_WIDTH bits of the second operand and delivers the product. Power
// (opcode 1) and inverse (opcode 2, exponent modulus - 2) use
// square-and-multiply: per exponent bit up to the highest set bit, the bit
// is tested, the accumulator is multiplied by the base when the bit is set,
// and the base is squared; each multiply is a double-and-add pass over the
// MOD_WIDTH bits of its multiplier. A modulus below 2 or opcode 3 yields 0
// without any arithmetic. The modulus is to be written through the cfg port
// while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module modular_mul_pow_inverse #(
  parameter int unsigned MOD_WIDTH = 31,
  parameter int unsigned EXP_WIDTH = 63
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [MOD_WIDTH-1:0]           cfg_data_i,
  // input words
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [mmpi_pkg::OPCODE_W-1:0]  opcode_i,
  input  logic [mmpi_pkg::FIRST_W-1:0]   first_operand_i,
  input  logic [EXP_WIDTH-1:0]           second_operand_i,
  // result words
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [MOD_WIDTH-1:0]           result_o
);

  import mmpi_pkg::*;

  localparam int unsigned YW      = (EXP_WIDTH > FIRST_W) ? EXP_WIDTH : FIRST_W;
  localparam int unsigned EW      = (EXP_WIDTH > MOD_WIDTH) ? EXP_WIDTH : MOD_WIDTH;
  localparam int unsigned CW      = $clog2(YW + 1);
  localparam int unsigned ShFirst = YW - FIRST_W;
  localparam int unsigned ShExp   = YW - EXP_WIDTH;
  localparam int unsigned ShMod   = YW - MOD_WIDTH;
  localparam logic [CW-1:0] CntFirst = CW'(FIRST_W);
  localparam logic [CW-1:0] CntExp   = CW'(EXP_WIDTH);
  localparam logic [CW-1:0] CntMod   = CW'(MOD_WIDTH);

  state_e               state_q, state_d;
  opcode_e              op_q, op_d;
  ret_e                 ret_q, ret_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [MOD_WIDTH-1:0] mod_q, mod_d;
  logic [MOD_WIDTH-1:0] base_q, base_d;
  logic [MOD_WIDTH-1:0] acc_q, acc_d;
  logic [MOD_WIDTH-1:0] prod_q, prod_d;
  logic [MOD_WIDTH-1:0] mcand_q, mcand_d;
  logic [MOD_WIDTH-1:0] res_q, res_d;
  logic [YW-1:0]        mplier_q, mplier_d;
  logic [EW-1:0]        exp_q, exp_d;

  logic                 add_cin;
  logic [MOD_WIDTH-1:0] add_b;
  logic [MOD_WIDTH-1:0] add_sum;
  logic                 last_bit;

  // Shared modular adder
  mmpi_modadd #(
    .W(MOD_WIDTH)
  ) u_modadd (
    .m_i  (mod_q),
    .a_i  (prod_q),
    .b_i  (add_b),
    .cin_i(add_cin),
    .sum_o(add_sum)
  );

  assign last_bit = (cnt_q == CW'(1));

  // Pick adder operands: double with shifted-in bit, or add the multiplicand
  always_comb begin
    add_b   = prod_q;
    add_cin = 1'b0;
    if (state_q == S_RED) begin
      add_cin = mplier_q[YW-1];
    end else if (state_q == S_ADD) begin
      add_b = mcand_q;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_DONE);
  assign result_o    = res_q;

  // Sequencer
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    ret_d    = ret_q;
    cnt_d    = cnt_q;
    mod_d    = mod_q;
    base_d   = base_q;
    acc_d    = acc_q;
    prod_d   = prod_q;
    mcand_d  = mcand_q;
    res_d    = res_q;
    mplier_d = mplier_q;
    exp_d    = exp_q;

    if (cfg_valid_i) begin
      mod_d = cfg_data_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = opcode_e'(opcode_i);
          mplier_d = YW'(first_operand_i) << ShFirst;
          cnt_d    = CntFirst;
          prod_d   = '0;
          if (opcode_e'(opcode_i) == OP_INV) begin
            exp_d = EW'(mod_q - MOD_WIDTH'(2));
          end else begin
            exp_d = EW'(second_operand_i);
          end
          if (mod_q < MOD_WIDTH'(2) || opcode_e'(opcode_i) == OP_NONE) begin
            res_d   = '0;
            state_d = S_DONE;
          end else begin
            state_d = S_RED;
          end
        end
      end

      // Reduce the first operand, one bit per cycle
      S_RED: begin
        prod_d   = add_sum;
        mplier_d = mplier_q << 1;
        cnt_d    = cnt_q - CW'(1);
        if (last_bit) begin
          base_d = add_sum;
          if (op_q == OP_MUL) begin
            mcand_d  = add_sum;
            mplier_d = YW'(exp_q[EXP_WIDTH-1:0]) << ShExp;
            cnt_d    = CntExp;
            prod_d   = '0;
            ret_d    = RET_OUT;
            state_d  = S_DBL;
          end else begin
            acc_d   = MOD_WIDTH'(1);
            state_d = S_PCHK;
          end
        end
      end

      // Next exponent bit: finish, multiply into acc, or square the base
      S_PCHK: begin
        prod_d   = '0;
        mplier_d = YW'(base_q) << ShMod;
        cnt_d    = CntMod;
        if (exp_q == '0) begin
          res_d   = acc_q;
          state_d = S_DONE;
        end else if (exp_q[0]) begin
          mcand_d = acc_q;
          ret_d   = RET_ACC;
          state_d = S_DBL;
        end else begin
          mcand_d = base_q;
          ret_d   = RET_BASE;
          state_d = S_DBL;
        end
      end

      // Double the partial product
      S_DBL: begin
        prod_d = add_sum;
        if (mplier_q[YW-1]) begin
          state_d = S_ADD;
        end else begin
          mplier_d = mplier_q << 1;
          cnt_d    = cnt_q - CW'(1);
          if (last_bit) begin
            state_d = S_MEND;
          end
        end
      end

      // Add the multiplicand for a set multiplier bit
      S_ADD: begin
        prod_d   = add_sum;
        mplier_d = mplier_q << 1;
        cnt_d    = cnt_q - CW'(1);
        state_d  = last_bit ? S_MEND : S_DBL;
      end

      // Deliver the finished product
      S_MEND: begin
        unique case (ret_q)
          RET_OUT: begin
            res_d   = prod_q;
            state_d = S_DONE;
          end
          RET_ACC: begin
            acc_d    = prod_q;
            mcand_d  = base_q;
            mplier_d = YW'(base_q) << ShMod;
            cnt_d    = CntMod;
            prod_d   = '0;
            ret_d    = RET_BASE;
            state_d  = S_DBL;
          end
          RET_BASE: begin
            base_d  = prod_q;
            exp_d   = exp_q >> 1;
            state_d = S_PCHK;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      // Hold the result word until taken
      S_DONE: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_MUL;
      ret_q   <= RET_OUT;
      cnt_q   <= '0;
      mod_q   <= MOD_WIDTH'(MODULUS_RESET);
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      ret_q   <= ret_d;
      cnt_q   <= cnt_d;
      mod_q   <= mod_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    base_q   <= base_d;
    acc_q    <= acc_d;
    prod_q   <= prod_d;
    mcand_q  <= mcand_d;
    res_q    <= res_d;
    mplier_q <= mplier_d;
    exp_q    <= exp_d;
  end

endmodule

// File: sv/mmpi_modadd.sv
// ----------------------------------------------------------------------------
// mmpi_modadd
// Shared modular adder: (a + b + cin) mod m, for a + b + cin < 2m.
// ----------------------------------------------------------------------------
module mmpi_modadd #(
  parameter int unsigned W = 31
) (
  input  logic [W-1:0] m_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         cin_i,
  output logic [W-1:0] sum_o
);

  logic [W:0] raw;
  logic [W:0] diff;

  // Add, then subtract the modulus once if the sum reached it
  assign raw   = {1'b0, a_i} + {1'b0, b_i} + {{W{1'b0}}, cin_i};
  assign diff  = raw - {1'b0, m_i};
  assign sum_o = (raw >= {1'b0, m_i}) ? diff[W-1:0] : raw[W-1:0];

endmodule
